### design/lcdsfw_pkg.sv
// Shared types, constants and lookup functions for the segment LCD shadow frame writer.
// Used by lcdsfw_shadow, lcdsfw_serializer and the top level; depends on nothing else.
package lcdsfw_pkg;

  localparam int RAM_WORDS   = 32;
  localparam int DIGIT_COUNT = 6;
  localparam int DEC_POINTS  = 5;

  localparam int ADDR_W  = 6;
  localparam int NIB_W   = 4;
  localparam int FRAME_W = 13;
  localparam int LEN_W   = 4;
  localparam int IDX_W   = $clog2(RAM_WORDS);
  localparam int CNT_W   = $clog2(RAM_WORDS + 1);

  localparam logic [2:0]       SYS_PREFIX = 3'b100;
  localparam logic [2:0]       RAM_PREFIX = 3'b101;
  localparam logic [LEN_W-1:0] SYS_LEN    = 4'd12;
  localparam logic [LEN_W-1:0] RAM_LEN    = 4'd13;
  localparam logic [NIB_W-1:0] NIB_CLEAR  = 4'h0;
  localparam logic [NIB_W-1:0] NIB_FULL   = 4'hF;

  typedef enum logic [2:0] {
    CMD_SYSTEM  = 3'd0,
    CMD_NIBBLE  = 3'd1,
    CMD_BIT     = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_ALL_ON  = 3'd4,
    CMD_SEGMENT = 3'd5,
    CMD_CHAR    = 3'd6,
    CMD_DECIMAL = 3'd7
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    cmd_code_t         command;
    logic [ADDR_W-1:0] address;
    logic [2:0]        bit_index;
    logic [NIB_W-1:0]  nibble_value;
    logic              bit_on;
    logic [2:0]        position;
    logic [6:0]        segments;
    logic [7:0]        char_code;
    logic [8:0]        command_word;
  } cmd_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_word;
    logic [LEN_W-1:0]   frame_length;
    logic               last_frame;
  } frame_item_t;

  // Load request from the sequencer to the serializer
  typedef struct packed {
    logic               load;
    logic [FRAME_W-1:0] word;
    logic [LEN_W-1:0]   len;
    logic               last;
  } frame_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [NIB_W-1:0] data;
  } shadow_wr_t;

  function automatic logic [6:0] digit_glyph(input logic [3:0] d);
    logic [6:0] g;
    case (d)
      4'd0:    g = 7'h3F;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5B;
      4'd3:    g = 7'h4F;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6D;
      4'd6:    g = 7'h7D;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7F;
      4'd9:    g = 7'h6F;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  // Letters match either case; anything without a glyph shows blank
  function automatic logic [6:0] char_glyph(input logic [7:0] c);
    logic [7:0] u;
    logic [6:0] g;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    if (c >= 8'h30 && c <= 8'h39) begin
      g = digit_glyph(c[3:0]);
    end else begin
      case (u)
        8'h41:   g = 7'h77;
        8'h42:   g = 7'h7C;
        8'h43:   g = 7'h39;
        8'h44:   g = 7'h5E;
        8'h45:   g = 7'h79;
        8'h46:   g = 7'h71;
        8'h48:   g = 7'h76;
        8'h49:   g = 7'h06;
        8'h4C:   g = 7'h38;
        8'h4E:   g = 7'h54;
        8'h4F:   g = 7'h3F;
        8'h50:   g = 7'h73;
        8'h52:   g = 7'h50;
        8'h53:   g = 7'h6D;
        8'h55:   g = 7'h3E;
        8'h59:   g = 7'h6E;
        8'h2D:   g = 7'h40;
        default: g = 7'h00;
      endcase
    end
    return g;
  endfunction

  // Decimal points live in bit 3 of the ABC nibbles, rightmost point first
  function automatic logic [ADDR_W-1:0] decimal_addr(input logic [2:0] p);
    logic [ADDR_W-1:0] a;
    case (p)
      3'd0:    a = 6'd14;
      3'd1:    a = 6'd12;
      3'd2:    a = 6'd10;
      3'd3:    a = 6'd8;
      default: a = 6'd6;
    endcase
    return a;
  endfunction

endpackage

### design/lcdsfw_shadow.sv
// Shadow copy of the controller display RAM, one nibble per word, cleared at reset.
// Registered read. Depends on lcdsfw_pkg for sizes and the write request struct.
module lcdsfw_shadow (
  input  logic                             clk,
  input  logic                             rst,
  input  lcdsfw_pkg::shadow_wr_t           wr,
  input  logic [lcdsfw_pkg::IDX_W-1:0]     rd_addr,
  output logic [lcdsfw_pkg::NIB_W-1:0]     rd_data
);

  logic [lcdsfw_pkg::NIB_W-1:0] words [lcdsfw_pkg::RAM_WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lcdsfw_pkg::RAM_WORDS; i++) begin
        words[i] <= lcdsfw_pkg::NIB_CLEAR;
      end
    end else if (wr.en) begin
      words[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= words[rd_addr];
  end

endmodule

### design/lcdsfw_serializer.sv
// Bit-serial frame assembler: shifts a frame MSB first, one bit per cycle, into
// an output shift register, then hands it to the output register. Uses lcdsfw_pkg.
module lcdsfw_serializer (
  input  logic                   clk,
  input  logic                   rst,
  input  lcdsfw_pkg::frame_req_t req,
  output logic                   ready,
  output logic                   frame_valid,
  input  logic                   frame_stall,
  output lcdsfw_pkg::frame_item_t frame
);

  localparam int FW = lcdsfw_pkg::FRAME_W;

  logic [FW-1:0]                 src;
  logic [FW-1:0]                 dst;
  logic [lcdsfw_pkg::LEN_W-1:0]  cnt;
  logic [lcdsfw_pkg::LEN_W-1:0]  len_r;
  logic                          last_r;
  logic                          busy;
  logic                          done;
  logic                          move;

  assign ready = !busy && !done;
  assign move  = done && (!frame_valid || !frame_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (req.load && ready) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else if (move) begin
        done <= 1'b0;
      end
      if (move) begin
        frame_valid <= 1'b1;
      end else if (frame_valid && !frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.load && ready) begin
      // left-align so the first bit sent always sits at the top
      src    <= (req.len == lcdsfw_pkg::SYS_LEN) ? {req.word[FW-2:0], 1'b0} : req.word;
      dst    <= '0;
      cnt    <= req.len;
      len_r  <= req.len;
      last_r <= req.last;
    end else if (busy) begin
      dst <= {dst[FW-2:0], src[FW-1]};
      src <= {src[FW-2:0], 1'b0};
      cnt <= cnt - 4'd1;
    end
    if (move) begin
      frame.frame_word   <= dst;
      frame.frame_length <= len_r;
      frame.last_frame   <= last_r;
    end
  end

endmodule

### design/segment_lcd_shadow_frame_writer_top.sv
// Top level of the segment LCD shadow frame writer: command sequencer, shadow RAM
// and bit-serial frame assembler. Depends on lcdsfw_pkg, lcdsfw_shadow, lcdsfw_serializer.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------
//   command  | cmd_valid / cmd_stall   | cmd   (lcdsfw_pkg::cmd_item_t)
//   frame    | frame_valid / frame_stall | frame (lcdsfw_pkg::frame_item_t)
//
// A command passes through a decode state, then each frame it yields goes through the
// serial assembler in steps: load, one shift per bit, move to the output register. A
// rejected command returns to idle from the decode state. Reset clears the shadow RAM
// at once, no clearing pass. cmd_stall stays high until the last frame of a command is
// loaded; frame_stall holds the output register and, behind it, one finished frame in
// the assembler.
module segment_lcd_shadow_frame_writer_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  lcdsfw_pkg::cmd_item_t   cmd,
  output logic                    frame_valid,
  input  logic                    frame_stall,
  output lcdsfw_pkg::frame_item_t frame
);

  localparam int AW = lcdsfw_pkg::ADDR_W;
  localparam int NW = lcdsfw_pkg::NIB_W;
  localparam int CW = lcdsfw_pkg::CNT_W;

  lcdsfw_pkg::ctrl_state_t state, state_next;
  lcdsfw_pkg::cmd_item_t   item;
  lcdsfw_pkg::frame_req_t  req;
  lcdsfw_pkg::shadow_wr_t  shadow_wr;

  logic [AW-1:0] cur_addr;
  logic [NW-1:0] cur_nib;
  logic [NW-1:0] second_nib;
  logic [CW-1:0] remaining;
  logic          is_sys;

  logic                        ser_ready;
  logic [AW-1:0]               cmd_addr;
  logic [AW-1:0]               rd_addr;
  logic [NW-1:0]               rd_data;
  logic [NW-1:0]               bit_mask;
  logic [NW-1:0]               bit_nib;
  logic [1:0]                  bit_sel;
  logic                        bit_set;
  logic [6:0]                  seg_pat;
  logic [AW-1:0]               digit_base;

  logic          dec_ok;
  logic          dec_sys;
  logic [AW-1:0] dec_addr;
  logic [NW-1:0] dec_nib;
  logic [NW-1:0] dec_nib2;
  logic [CW-1:0] dec_count;
  logic          emit;

  // Look up the shadow word during the command transfer; the data is ready in decode
  assign cmd_addr = (cmd.command == lcdsfw_pkg::CMD_DECIMAL) ?
                    lcdsfw_pkg::decimal_addr(cmd.position) : cmd.address;

  lcdsfw_shadow u_shadow (
    .clk     (clk),
    .rst     (rst),
    .wr      (shadow_wr),
    .rd_addr (cmd_addr[lcdsfw_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  lcdsfw_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .ready       (ser_ready),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame)
  );

  // Decode the held command into a run of RAM frames at consecutive addresses, or one system frame
  always_comb begin
    rd_addr    = (item.command == lcdsfw_pkg::CMD_DECIMAL) ?
                 lcdsfw_pkg::decimal_addr(item.position) : item.address;
    bit_sel    = (item.command == lcdsfw_pkg::CMD_DECIMAL) ? 2'd3 : item.bit_index[1:0];
    bit_mask   = 4'(1) << bit_sel;
    bit_set    = item.bit_on;
    bit_nib    = bit_set ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    seg_pat    = (item.command == lcdsfw_pkg::CMD_CHAR) ?
                 lcdsfw_pkg::char_glyph(item.char_code) : item.segments;
    digit_base = 6'd4 + {2'b00, item.position, 1'b0};

    dec_ok    = 1'b0;
    dec_sys   = 1'b0;
    dec_addr  = rd_addr;
    dec_nib   = bit_nib;
    dec_nib2  = bit_nib;
    dec_count = CW'(1);
    unique case (item.command)
      lcdsfw_pkg::CMD_SYSTEM: begin
        dec_ok  = 1'b1;
        dec_sys = 1'b1;
      end
      lcdsfw_pkg::CMD_NIBBLE: begin
        dec_ok  = int'(item.address) < lcdsfw_pkg::RAM_WORDS;
        dec_nib = item.nibble_value;
      end
      lcdsfw_pkg::CMD_BIT: begin
        dec_ok = (int'(item.address) < lcdsfw_pkg::RAM_WORDS) && !item.bit_index[2];
      end
      lcdsfw_pkg::CMD_CLEAR, lcdsfw_pkg::CMD_ALL_ON: begin
        dec_ok    = 1'b1;
        dec_addr  = '0;
        dec_nib   = (item.command == lcdsfw_pkg::CMD_ALL_ON) ?
                    lcdsfw_pkg::NIB_FULL : lcdsfw_pkg::NIB_CLEAR;
        dec_nib2  = dec_nib;
        dec_count = CW'(lcdsfw_pkg::RAM_WORDS);
      end
      lcdsfw_pkg::CMD_SEGMENT, lcdsfw_pkg::CMD_CHAR: begin
        dec_ok    = int'(item.position) < lcdsfw_pkg::DIGIT_COUNT;
        dec_addr  = digit_base;
        dec_nib   = {1'b0, seg_pat[2:0]};
        dec_nib2  = {seg_pat[3], seg_pat[4], seg_pat[6], seg_pat[5]};
        dec_count = CW'(2);
      end
      lcdsfw_pkg::CMD_DECIMAL: begin
        dec_ok = int'(item.position) < lcdsfw_pkg::DEC_POINTS;
      end
      default: dec_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lcdsfw_pkg::ST_IDLE:   if (cmd_valid) state_next = lcdsfw_pkg::ST_DECODE;
      lcdsfw_pkg::ST_DECODE: state_next = dec_ok ? lcdsfw_pkg::ST_EMIT : lcdsfw_pkg::ST_IDLE;
      lcdsfw_pkg::ST_EMIT:   if (ser_ready && remaining == CW'(1))
                               state_next = lcdsfw_pkg::ST_IDLE;
      default:               state_next = lcdsfw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall = 1'b1;
    emit      = 1'b0;
    unique case (state)
      lcdsfw_pkg::ST_IDLE:   cmd_stall = 1'b0;
      lcdsfw_pkg::ST_DECODE: cmd_stall = 1'b1;
      lcdsfw_pkg::ST_EMIT:   emit      = ser_ready;
      default:               cmd_stall = 1'b1;
    endcase
  end

  assign req.load = emit;
  assign req.word = is_sys ? {1'b0, lcdsfw_pkg::SYS_PREFIX, item.command_word}
                           : {lcdsfw_pkg::RAM_PREFIX, cur_addr, cur_nib};
  assign req.len  = is_sys ? lcdsfw_pkg::SYS_LEN : lcdsfw_pkg::RAM_LEN;
  assign req.last = (remaining == CW'(1));

  assign shadow_wr.en   = emit && !is_sys;
  assign shadow_wr.addr = cur_addr[lcdsfw_pkg::IDX_W-1:0];
  assign shadow_wr.data = cur_nib;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdsfw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      item <= cmd;
    end
    if (state == lcdsfw_pkg::ST_DECODE) begin
      is_sys     <= dec_sys;
      cur_addr   <= dec_addr;
      cur_nib    <= dec_nib;
      second_nib <= dec_nib2;
      remaining  <= dec_count;
    end else if (emit) begin
      // advance to the next word of the run
      cur_addr  <= cur_addr + AW'(1);
      cur_nib   <= second_nib;
      remaining <= remaining - CW'(1);
    end
  end

endmodule
